/* sv/stereo_comb_allpass_reverb_macros.svh */
`ifndef STEREO_COMB_ALLPASS_REVERB_MACROS_SVH
`define STEREO_COMB_ALLPASS_REVERB_MACROS_SVH

// Same-cycle implication, sampled on the rising edge of clk, off during reset.
`define SCAR_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("reverb assertion failed");

// Next-cycle implication.
`define SCAR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("reverb assertion failed");

`endif

/* sv/scar_pkg.sv */
`timescale 1ns / 1ps
package scar_pkg;

	localparam int SAMPLE_W      = 24;
	localparam int COMB_COUNT    = 8;
	localparam int COMB_LINES    = 2 * COMB_COUNT;
	localparam int ALLPASS_COUNT = 4;
	localparam int AP_LINES      = 2 * ALLPASS_COUNT;
	localparam int COMB_DEPTH    = 2048;
	localparam int AP_DEPTH      = 1024;
	localparam int COMB_WORDS    = COMB_LINES * COMB_DEPTH;
	localparam int AP_WORDS      = AP_LINES * AP_DEPTH;
	localparam int COMB_AW       = $clog2(COMB_WORDS);
	localparam int AP_AW         = $clog2(AP_WORDS);
	localparam int CLINE_W       = $clog2(COMB_LINES);
	localparam int APK_W         = $clog2(ALLPASS_COUNT);
	localparam int APL_W         = $clog2(AP_LINES);
	localparam int CPOS_W        = $clog2(COMB_DEPTH);
	localparam int APOS_W        = $clog2(AP_DEPTH);
	localparam int MA_W          = 32;
	localparam int MB_W          = 18;
	localparam int PROD_W        = MA_W + MB_W;

	localparam logic signed [MB_W-1:0] GAIN_IN   = 18'sd492;
	localparam logic signed [MB_W-1:0] GAIN_TANH = 18'sd39322;
	localparam logic [16:0] ONE_Q15 = 17'd32768;
	localparam logic [15:0] MIX_MAX = 16'd32768;
	localparam logic [15:0] MIX_MIN = 16'd4;
	localparam logic [1:0]  PRESET_TANH = 2'd2;

	// Line lengths; the right-channel combs carry the stereo spread of 23.
	localparam logic [11:0] COMB_LEN [COMB_LINES] = '{
		12'd1116, 12'd1188, 12'd1277, 12'd1356, 12'd1422, 12'd1491, 12'd1557, 12'd1617,
		12'd1139, 12'd1211, 12'd1300, 12'd1379, 12'd1445, 12'd1514, 12'd1580, 12'd1640};
	localparam logic [10:0] AP_LEN [ALLPASS_COUNT] = '{11'd556, 11'd441, 11'd341, 11'd225};

	// Preset code three behaves as two.
	localparam logic [15:0] FB_TAB [4]   = '{16'd26214, 16'd29819, 16'd31785, 16'd31785};
	localparam logic [15:0] DAMP_TAB [4] = '{16'd16384, 16'd9830, 16'd3277, 16'd3277};

	typedef logic signed [SAMPLE_W-1:0] scar_sample_t;

	typedef struct packed {
		scar_sample_t left_in;
		scar_sample_t right_in;
	} scar_in_t;

	typedef struct packed {
		scar_sample_t left_out;
		scar_sample_t right_out;
	} scar_out_t;

	typedef struct packed {
		logic        enable;
		logic [1:0]  preset;
		logic [15:0] mix;
	} scar_cfg_t;

	typedef struct packed {
		logic start;
		logic clear;
		logic take;
	} scar_ctl_t;

	typedef struct packed {
		logic idle;
		logic done;
	} scar_stat_t;

	typedef enum logic [1:0] {
		CFG_ENABLE = 2'd0,
		CFG_PRESET = 2'd1,
		CFG_MIX    = 2'd2
	} scar_cfg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_FEED,
		ST_CB_RD,
		ST_CB_M1,
		ST_CB_M2,
		ST_CB_LP,
		ST_CB_M3,
		ST_CB_WR,
		ST_SS_M1,
		ST_SS_IDX,
		ST_SS_M2,
		ST_SS_FIN,
		ST_AP_RD,
		ST_AP_WR,
		ST_MX_M1,
		ST_MX_M2,
		ST_MX_FIN,
		ST_DONE
	} scar_state_t;

	typedef logic signed [SAMPLE_W-1:0] scar_tanh_tab_t [256];

	// Shift-and-subtract quotient, used only while the table is built at elaboration.
	function automatic longint unsigned udiv64(input longint unsigned a,
		input longint unsigned b);
		longint unsigned q;
		logic [64:0]     rem;
		q   = '0;
		rem = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], a[i]};
			if (rem >= {1'b0, b}) begin
				rem  = rem - {1'b0, b};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// Integer tanh(k/64)/1.2 in Q0.23 from a series for exp(k/32).
	function automatic scar_tanh_tab_t build_tanh();
		scar_tanh_tab_t tab;
		longint unsigned term, sum, e23, num, den;
		for (int k = 0; k < 256; k++) begin
			term = 64'd1 << 40;
			sum  = term;
			for (int n = 1; n < 100; n++) begin
				if (term != 64'd0) begin
					term = udiv64(term * 64'(k), 64'd32 * 64'(n));
					sum  = sum + term;
				end
			end
			e23 = sum >> 17;
			num = (e23 - (64'd1 << 23)) * 64'd5 * (64'd1 << 23);
			den = (e23 + (64'd1 << 23)) * 64'd6;
			tab[k] = SAMPLE_W'(udiv64(num + (den >> 1), den));
		end
		return tab;
	endfunction

	localparam scar_tanh_tab_t TANH_TAB = build_tanh();

	function automatic scar_sample_t sat24(input logic signed [63:0] x);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = (64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1;
		lo = -hi - 64'sd1;
		if (x > hi) begin
			return SAMPLE_W'(hi);
		end else if (x < lo) begin
			return SAMPLE_W'(lo);
		end
		return SAMPLE_W'(x);
	endfunction

endpackage

/* sv/scar_ram.sv */
`timescale 1ns / 1ps
module scar_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 24
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* sv/scar_core.sv */
`timescale 1ns / 1ps
module scar_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  scar_pkg::scar_cfg_t  cfg,
	input  scar_pkg::scar_ctl_t  ctl,
	input  scar_pkg::scar_in_t   in_data,
	output scar_pkg::scar_stat_t stat,
	output scar_pkg::scar_out_t  res
);

	scar_pkg::scar_state_t state_q, state_d;

	logic [scar_pkg::CLINE_W-1:0] line_q;
	logic [scar_pkg::APK_W-1:0]   apk_q;
	logic                         ch_q;
	logic                         clr_busy_q;
	logic [scar_pkg::COMB_AW-1:0] clr_q;

	logic [scar_pkg::CPOS_W-1:0] comb_pos_q [scar_pkg::COMB_LINES];
	scar_pkg::scar_sample_t      comb_lp_q [scar_pkg::COMB_LINES];
	logic [scar_pkg::APOS_W-1:0] ap_pos_q [scar_pkg::AP_LINES];

	logic signed [scar_pkg::PROD_W-1:0] prod_q, sum_q;
	logic signed [19:0]                 feed_q;
	scar_pkg::scar_sample_t             lp_q, t0_q, l_q, r_q, res_l_q, res_r_q;
	logic signed [31:0]                 acc_l_q, acc_r_q;
	logic [scar_pkg::COMB_AW-1:0]       addr_c_q;
	logic [scar_pkg::AP_AW-1:0]         addr_a_q;
	logic                               neg_q, big_q;
	logic [34:0]                        ax_q;

	logic signed [scar_pkg::MA_W-1:0]   mul_a;
	logic signed [scar_pkg::MB_W-1:0]   mul_b;
	logic signed [scar_pkg::PROD_W-1:0] mul_p;

	logic                         c_we, a_we;
	logic [scar_pkg::COMB_AW-1:0] c_waddr, c_raddr;
	logic [scar_pkg::AP_AW-1:0]   a_waddr, a_raddr;
	scar_pkg::scar_sample_t       c_wdata, a_wdata, c_rdata, a_rdata;

	logic [15:0]                  mix_c, fb, damp;
	logic [16:0]                  omd;
	logic                         bypass, ps_tanh, comb_last, apk_last;
	logic [scar_pkg::APL_W-1:0]   ap_line;
	logic [scar_pkg::CPOS_W-1:0]  cpos, cpos_nx;
	logic [scar_pkg::APOS_W-1:0]  apos, apos_nx;
	logic signed [31:0]           w_sel, in_sel;
	logic signed [24:0]           lr;
	logic signed [50:0]           wide_sum;
	scar_pkg::scar_sample_t       lp_d;
	logic signed [34:0]           x_d;
	logic [17:0]                  idx;
	logic [7:0]                   i8;
	logic                         big_d;
	scar_pkg::scar_sample_t       t0_d, t1_d;
	logic signed [24:0]           diff_d, ys;

	assign mix_c     = (cfg.mix > scar_pkg::MIX_MAX) ? scar_pkg::MIX_MAX : cfg.mix;
	assign bypass    = !cfg.enable || (mix_c < scar_pkg::MIX_MIN);
	assign ps_tanh   = (cfg.preset == scar_pkg::PRESET_TANH);
	assign fb        = scar_pkg::FB_TAB[cfg.preset];
	assign damp      = scar_pkg::DAMP_TAB[cfg.preset];
	assign omd       = scar_pkg::ONE_Q15 - 17'(damp);
	assign comb_last = (line_q == scar_pkg::CLINE_W'(scar_pkg::COMB_LINES - 1));
	assign apk_last  = (apk_q == scar_pkg::APK_W'(scar_pkg::ALLPASS_COUNT - 1));
	assign ap_line   = {ch_q, apk_q};
	assign cpos      = comb_pos_q[line_q];
	assign apos      = ap_pos_q[ap_line];
	assign cpos_nx   = (12'(cpos) + 12'd1 >= scar_pkg::COMB_LEN[line_q]) ? '0 : cpos + 1'b1;
	assign apos_nx   = (11'(apos) + 11'd1 >= scar_pkg::AP_LEN[apk_q]) ? '0 : apos + 1'b1;
	assign w_sel     = ch_q ? acc_r_q : acc_l_q;
	assign in_sel    = ch_q ? 32'(r_q) : 32'(l_q);
	assign lr        = 25'(l_q) + 25'(r_q);
	assign wide_sum  = 51'(sum_q) + 51'(prod_q);
	assign lp_d      = wide_sum[38:15];
	assign x_d       = prod_q[49:15];
	assign idx       = ax_q[34:17];
	assign i8        = idx[7:0];
	assign big_d     = (idx >= 18'd255);
	assign t0_d      = scar_pkg::TANH_TAB[i8];
	assign t1_d      = scar_pkg::TANH_TAB[i8 + 8'd1];
	assign diff_d    = 25'(t1_d) - 25'(t0_d);
	assign ys        = big_q ? 25'(scar_pkg::TANH_TAB[255]) : 25'(t0_q) + 25'(prod_q >>> 17);
	assign mul_p     = mul_a * mul_b;

	scar_ram #(.DEPTH(scar_pkg::COMB_WORDS), .WIDTH(scar_pkg::SAMPLE_W)) u_comb_ram (
		.clk  (clk),
		.we   (c_we),
		.waddr(c_waddr),
		.wdata(c_wdata),
		.raddr(c_raddr),
		.rdata(c_rdata)
	);

	scar_ram #(.DEPTH(scar_pkg::AP_WORDS), .WIDTH(scar_pkg::SAMPLE_W)) u_ap_ram (
		.clk  (clk),
		.we   (a_we),
		.waddr(a_waddr),
		.wdata(a_wdata),
		.raddr(a_raddr),
		.rdata(a_rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			scar_pkg::ST_IDLE: begin
				if (ctl.start) begin
					state_d = bypass ? scar_pkg::ST_DONE : scar_pkg::ST_FEED;
				end
			end
			scar_pkg::ST_FEED:   state_d = scar_pkg::ST_CB_RD;
			scar_pkg::ST_CB_RD:  state_d = scar_pkg::ST_CB_M1;
			scar_pkg::ST_CB_M1:  state_d = scar_pkg::ST_CB_M2;
			scar_pkg::ST_CB_M2:  state_d = scar_pkg::ST_CB_LP;
			scar_pkg::ST_CB_LP:  state_d = scar_pkg::ST_CB_M3;
			scar_pkg::ST_CB_M3:  state_d = scar_pkg::ST_CB_WR;
			scar_pkg::ST_CB_WR: begin
				if (comb_last) begin
					state_d = ps_tanh ? scar_pkg::ST_SS_M1 : scar_pkg::ST_AP_RD;
				end else begin
					state_d = scar_pkg::ST_CB_RD;
				end
			end
			scar_pkg::ST_SS_M1:  state_d = scar_pkg::ST_SS_IDX;
			scar_pkg::ST_SS_IDX: state_d = scar_pkg::ST_SS_M2;
			scar_pkg::ST_SS_M2:  state_d = scar_pkg::ST_SS_FIN;
			scar_pkg::ST_SS_FIN: state_d = scar_pkg::ST_AP_RD;
			scar_pkg::ST_AP_RD:  state_d = scar_pkg::ST_AP_WR;
			scar_pkg::ST_AP_WR: begin
				state_d = apk_last ? scar_pkg::ST_MX_M1 : scar_pkg::ST_AP_RD;
			end
			scar_pkg::ST_MX_M1:  state_d = scar_pkg::ST_MX_M2;
			scar_pkg::ST_MX_M2:  state_d = scar_pkg::ST_MX_FIN;
			scar_pkg::ST_MX_FIN: begin
				if (ch_q) begin
					state_d = scar_pkg::ST_DONE;
				end else begin
					state_d = ps_tanh ? scar_pkg::ST_SS_M1 : scar_pkg::ST_AP_RD;
				end
			end
			scar_pkg::ST_DONE: begin
				if (ctl.take) begin
					state_d = scar_pkg::ST_IDLE;
				end
			end
			default: state_d = scar_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		c_we    = 1'b0;
		c_waddr = addr_c_q;
		c_wdata = '0;
		c_raddr = {line_q, cpos};
		a_we    = 1'b0;
		a_waddr = addr_a_q;
		a_wdata = '0;
		a_raddr = {ap_line, apos};
		unique case (state_q)
			scar_pkg::ST_FEED: begin
				mul_a = 32'(lr);
				mul_b = scar_pkg::GAIN_IN;
			end
			scar_pkg::ST_CB_M1: begin
				mul_a = 32'(c_rdata);
				mul_b = {1'b0, omd};
			end
			scar_pkg::ST_CB_M2: begin
				mul_a = 32'(comb_lp_q[line_q]);
				mul_b = {2'b00, damp};
			end
			scar_pkg::ST_CB_M3: begin
				mul_a = 32'(lp_q);
				mul_b = {2'b00, fb};
			end
			scar_pkg::ST_CB_WR: begin
				c_we    = 1'b1;
				c_wdata = scar_pkg::sat24(64'(feed_q) + 64'(prod_q >>> 15));
			end
			scar_pkg::ST_SS_M1: begin
				mul_a = w_sel;
				mul_b = scar_pkg::GAIN_TANH;
			end
			scar_pkg::ST_SS_M2: begin
				mul_a = 32'(diff_d);
				mul_b = {1'b0, ax_q[16:0]};
			end
			scar_pkg::ST_AP_WR: begin
				a_we    = 1'b1;
				a_wdata = scar_pkg::sat24(64'(w_sel) + 64'(a_rdata >>> 1));
			end
			scar_pkg::ST_MX_M1: begin
				mul_a = w_sel;
				mul_b = {2'b00, mix_c};
			end
			scar_pkg::ST_MX_M2: begin
				mul_a = in_sel;
				mul_b = {1'b0, scar_pkg::ONE_Q15 - 17'(mix_c)};
			end
			default: begin
			end
		endcase
		// The clearing pass owns both write ports; new items wait for it.
		if (clr_busy_q) begin
			c_we    = 1'b1;
			c_waddr = clr_q;
			c_wdata = '0;
			a_we    = (32'(clr_q) < scar_pkg::AP_WORDS);
			a_waddr = clr_q[scar_pkg::AP_AW-1:0];
			a_wdata = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= scar_pkg::ST_IDLE;
			line_q     <= '0;
			apk_q      <= '0;
			ch_q       <= 1'b0;
			clr_busy_q <= 1'b1;
			clr_q      <= '0;
			for (int i = 0; i < scar_pkg::COMB_LINES; i++) begin
				comb_pos_q[i] <= '0;
				comb_lp_q[i]  <= '0;
			end
			for (int i = 0; i < scar_pkg::AP_LINES; i++) begin
				ap_pos_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			case (state_q)
				scar_pkg::ST_IDLE: begin
					line_q <= '0;
					apk_q  <= '0;
					ch_q   <= 1'b0;
				end
				scar_pkg::ST_CB_LP: comb_lp_q[line_q] <= lp_d;
				scar_pkg::ST_CB_WR: begin
					comb_pos_q[line_q] <= cpos_nx;
					line_q             <= line_q + 1'b1;
				end
				scar_pkg::ST_AP_WR: begin
					ap_pos_q[ap_line] <= apos_nx;
					apk_q             <= apk_q + 1'b1;
				end
				scar_pkg::ST_MX_FIN: ch_q <= 1'b1;
				default: begin
				end
			endcase
			if (ctl.clear) begin
				clr_busy_q <= 1'b1;
				clr_q      <= '0;
				for (int i = 0; i < scar_pkg::COMB_LINES; i++) begin
					comb_pos_q[i] <= '0;
					comb_lp_q[i]  <= '0;
				end
				for (int i = 0; i < scar_pkg::AP_LINES; i++) begin
					ap_pos_q[i] <= '0;
				end
			end else if (clr_busy_q) begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == '1) begin
					clr_busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		case (state_q)
			scar_pkg::ST_IDLE: begin
				if (ctl.start) begin
					l_q     <= in_data.left_in;
					r_q     <= in_data.right_in;
					res_l_q <= in_data.left_in;
					res_r_q <= in_data.right_in;
					acc_l_q <= '0;
					acc_r_q <= '0;
				end
			end
			scar_pkg::ST_CB_RD: begin
				// The feed product is still in the product register for the first line.
				if (line_q == '0) begin
					feed_q <= prod_q[34:15];
				end
				addr_c_q <= {line_q, cpos};
			end
			scar_pkg::ST_CB_M1: begin
				if (32'(line_q) < scar_pkg::COMB_COUNT) begin
					acc_l_q <= acc_l_q + 32'(c_rdata);
				end else begin
					acc_r_q <= acc_r_q + 32'(c_rdata);
				end
			end
			scar_pkg::ST_CB_M2: sum_q <= prod_q;
			scar_pkg::ST_CB_LP: lp_q <= lp_d;
			scar_pkg::ST_SS_IDX: begin
				neg_q <= x_d[34];
				ax_q  <= x_d[34] ? 35'(-x_d) : 35'(x_d);
			end
			scar_pkg::ST_SS_M2: begin
				t0_q  <= t0_d;
				big_q <= big_d;
			end
			scar_pkg::ST_SS_FIN: begin
				if (ch_q) begin
					acc_r_q <= neg_q ? -32'(ys) : 32'(ys);
				end else begin
					acc_l_q <= neg_q ? -32'(ys) : 32'(ys);
				end
			end
			scar_pkg::ST_AP_RD: addr_a_q <= {ap_line, apos};
			scar_pkg::ST_AP_WR: begin
				if (ch_q) begin
					acc_r_q <= 32'(a_rdata) - w_sel;
				end else begin
					acc_l_q <= 32'(a_rdata) - w_sel;
				end
			end
			scar_pkg::ST_MX_M2: sum_q <= prod_q;
			scar_pkg::ST_MX_FIN: begin
				if (ch_q) begin
					res_r_q <= scar_pkg::sat24(64'(wide_sum >>> 15));
				end else begin
					res_l_q <= scar_pkg::sat24(64'(wide_sum >>> 15));
				end
			end
			default: begin
			end
		endcase
	end

	assign stat.idle     = (state_q == scar_pkg::ST_IDLE) && !clr_busy_q;
	assign stat.done     = (state_q == scar_pkg::ST_DONE);
	assign res.left_out  = res_l_q;
	assign res.right_out = res_r_q;

endmodule

/* sv/stereo_comb_allpass_reverb.sv */
// One request is processed at a time: in_stall stays high from acceptance until the result is
// handed to the output register; in bypass the inputs pass through unchanged. One shared
// multiplier walks the 16 comb lines, then per channel a tanh saturator on preset 2 and 4 allpass stages.
// Reset: enable=1, preset 0, mix 0; a clearing pass over all 32768 comb words zeroes the delay
// memories after reset and after every preset write, and requests wait until it ends.
`timescale 1ns / 1ps
`include "stereo_comb_allpass_reverb_macros.svh"
module stereo_comb_allpass_reverb (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  scar_pkg::scar_in_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output scar_pkg::scar_out_t out_data,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data
);

	scar_pkg::scar_cfg_t  cfg_q;
	scar_pkg::scar_ctl_t  ctl;
	scar_pkg::scar_stat_t stat;
	scar_pkg::scar_out_t  res;
	scar_pkg::scar_out_t  out_data_q;
	logic                 out_valid_q;

	assign in_stall  = !stat.idle;
	assign ctl.start = in_valid && !in_stall;
	assign ctl.clear = cfg_we && (cfg_index == scar_pkg::CFG_PRESET);
	assign ctl.take  = stat.done && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable <= 1'b1;
			cfg_q.preset <= '0;
			cfg_q.mix    <= '0;
		end else if (cfg_we) begin
			unique case (scar_pkg::scar_cfg_idx_t'(cfg_index))
				scar_pkg::CFG_ENABLE: cfg_q.enable <= cfg_data[0];
				scar_pkg::CFG_PRESET: begin
					cfg_q.preset <= (cfg_data[1:0] > scar_pkg::PRESET_TANH) ?
						scar_pkg::PRESET_TANH : cfg_data[1:0];
				end
				scar_pkg::CFG_MIX:    cfg_q.mix <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	scar_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.ctl    (ctl),
		.in_data(in_data),
		.stat   (stat),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`SCAR_ASSERT_NEXT(a_busy_after_start, ctl.start, in_stall)
	`SCAR_ASSERT_NEXT(a_clear_stalls, ctl.clear, in_stall)
	`SCAR_ASSERT_NEXT(a_take_loads_output, ctl.take, out_valid)
	`SCAR_ASSERT_IMPL(a_no_take_when_full, out_valid && out_stall, !ctl.take)

endmodule
